// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the RTL of the shared-array stack block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
	else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
	else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

// ===== rtl/core/sams_pkg.sv =====
// Types and constants for the shared-array multi-stack block
`default_nettype none
package sams_pkg;
	localparam int MemDepth   = 256;
	localparam int StackCount = 4;
	localparam int DataWidth  = 32;
	localparam int AddrW      = $clog2(MemDepth);
	localparam int CntW       = AddrW + 1;
	localparam int SelW       = 2;
	localparam int IdxW       = (StackCount > 1) ? $clog2(StackCount) : 1;
	localparam int Part       = MemDepth / StackCount;
	localparam int LastPart   = MemDepth - Part * (StackCount - 1);

	localparam logic [1:0] StOk        = 2'd0;
	localparam logic [1:0] StPopEmpty  = 2'd1;
	localparam logic [1:0] StPushFull  = 2'd2;
	localparam logic       ActPush     = 1'b0;
	localparam logic       ActPop      = 1'b1;

	typedef logic [CntW-1:0] cnt_t;
	typedef logic [AddrW-1:0] addr_t;
	typedef logic [DataWidth-1:0] data_t;

	// memory port request from the sequencer
	typedef struct packed {
		logic  rd;
		logic  wr;
		addr_t addr;
		data_t wdata;
	} mem_req_t;
endpackage
`default_nettype wire

// ===== rtl/core/sams_mem.sv =====
// Element memory: one write or read port, registered read data
`default_nettype none
module sams_mem
	import sams_pkg::*;
(
	input  wire      clk,
	input  mem_req_t req,
	output data_t    rdata
);
	data_t mem_q [MemDepth];

	always_ff @(posedge clk) begin
		if (req.wr) mem_q[req.addr] <= req.wdata;
		if (req.rd) rdata <= mem_q[req.addr];
	end
endmodule
`default_nettype wire

// ===== rtl/core/shared_array_multi_stack_top.sv =====
// Top level: several stacks in one element memory, with relocation on overflow
// Push without relocation: result registered in S_ACC; pop: read in S_ACC,
// result in S_POPW. Relocation (sum, plan, element moves) precedes the access.
// One item at a time: the next beat is taken the cycle after the result is taken;
// the memory port and sequencer set this.
// Reset (arst_n low) restores the even split and empties all stacks; memory undefined.
`default_nettype none
`include "assert_macros.svh"
module shared_array_multi_stack_top
	import sams_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [39:0] s_axis_tdata,  // action, stack_sel[1:0], push_value[31:0], zero pad
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [39:0] m_axis_tdata   // pop_value[31:0], status[1:0], now_empty, now_full, pad
);
	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_SUM   = 9'b000000010,
		S_PLAN  = 9'b000000100,
		S_DNSEL = 9'b000001000,
		S_DNRD  = 9'b000010000,
		S_UPSEL = 9'b000100000,
		S_UPRD  = 9'b001000000,
		S_ACC   = 9'b010000000,
		S_POPW  = 9'b100000000
	} state_t;

	state_t state_q;
	cnt_t base_q [StackCount];
	cnt_t cap_q  [StackCount];
	cnt_t fill_q [StackCount];
	cnt_t nbase_q [StackCount];
	cnt_t ncap_q  [StackCount];
	logic        act_q;
	logic [SelW-1:0] sel_q;
	data_t       val_q;
	logic        reloc_q;
	cnt_t        free_q, acc_q;
	logic [IdxW:0] i_q;
	cnt_t        j_q;
	logic        out_v_q;
	data_t       out_pop_q;
	logic [1:0]  out_st_q;
	logic        out_e_q, out_f_q;
	mem_req_t    req;
	data_t       rdata;
	logic        wb_q;
	addr_t       wb_addr_q;

	sams_mem u_mem (.clk(clk), .req(req), .rdata(rdata));

	logic [IdxW-1:0] si, ii;
	logic sel_ok;
	cnt_t share, slack;
	assign si = sel_q[IdxW-1:0];
	assign ii = i_q[IdxW-1:0];
	assign sel_ok = ({{(32-SelW){1'b0}}, sel_q} < 32'(StackCount));
	assign share = cnt_t'(free_q / StackCount);
	assign slack = (cap_q[ii] > fill_q[ii]) ? cap_q[ii] - fill_q[ii] : '0;

	// move address: downward ascending j, upward descending j
	cnt_t mv_src, mv_dst;
	always_comb begin
		mv_src = base_q[ii] + j_q;
		mv_dst = nbase_q[ii] + j_q;
		req = '0;
		unique case (state_q)
			S_DNRD, S_UPRD: begin
				req.rd = 1'b1;
				req.addr = addr_t'(mv_src);
			end
			S_ACC: begin
				if (act_q == ActPush && fill_q[si] < cap_q[si]) begin
					req.wr = 1'b1;
					req.addr = addr_t'(base_q[si] + fill_q[si]);
					req.wdata = val_q;
				end else if (act_q == ActPop && fill_q[si] != '0) begin
					req.rd = 1'b1;
					req.addr = addr_t'(base_q[si] + fill_q[si] - 1'b1);
				end
			end
			default: ;
		endcase
		// write the word read last cycle
		if (wb_q) begin
			req.wr = 1'b1;
			req.rd = 1'b0;
			req.addr = wb_addr_q;
			req.wdata = rdata;
		end
	end

	assign s_axis_tready = (state_q == S_IDLE) && !out_v_q;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {4'b0, out_f_q, out_e_q, out_st_q, out_pop_q};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_v_q <= 1'b0;
			wb_q <= 1'b0;
			for (int k = 0; k < StackCount; k++) begin
				base_q[k] <= cnt_t'(k * Part);
				cap_q[k]  <= cnt_t'((k == StackCount - 1) ? LastPart : Part);
				fill_q[k] <= '0;
			end
		end else begin
			wb_q <= 1'b0;
			if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
					act_q <= s_axis_tdata[0];
					sel_q <= s_axis_tdata[2:1];
					val_q <= s_axis_tdata[34:3];
					state_q <= S_ACC;
					reloc_q <= 1'b0;
				end
				S_SUM: begin
					if (i_q == (IdxW+1)'(StackCount)) begin
						i_q <= '0;
						acc_q <= '0;
						state_q <= (free_q == '0) ? S_ACC : S_PLAN;
						reloc_q <= 1'b1;
					end else begin
						free_q <= free_q + slack;
						i_q <= i_q + 1'b1;
					end
				end
				S_PLAN: begin
					if (i_q == (IdxW+1)'(StackCount)) begin
						i_q <= '0;
						j_q <= '0;
						state_q <= S_DNSEL;
					end else begin
						ncap_q[ii] <= fill_q[ii] + ((i_q == (IdxW+1)'(StackCount - 1))
							? free_q - share * cnt_t'(StackCount - 1) : share);
						nbase_q[ii] <= acc_q;
						acc_q <= acc_q + fill_q[ii] + ((i_q == (IdxW+1)'(StackCount - 1))
							? free_q - share * cnt_t'(StackCount - 1) : share);
						i_q <= i_q + 1'b1;
					end
				end
				S_DNSEL: begin
					if (i_q == (IdxW+1)'(StackCount)) begin
						i_q <= (IdxW+1)'(StackCount - 1);
						state_q <= S_UPSEL;
						j_q <= fill_q[StackCount-1];
					end else if (nbase_q[ii] < base_q[ii] && j_q < fill_q[ii]) begin
						state_q <= S_DNRD;
					end else begin
						i_q <= i_q + 1'b1;
						j_q <= '0;
					end
				end
				S_DNRD: begin
					wb_q <= 1'b1;
					wb_addr_q <= addr_t'(mv_dst);
					j_q <= j_q + 1'b1;
					state_q <= S_DNSEL;
				end
				S_UPSEL: begin
					if (nbase_q[ii] > base_q[ii] && j_q != '0) begin
						j_q <= j_q - 1'b1;
						state_q <= S_UPRD;
					end else if (i_q == '0) begin
						for (int k = 0; k < StackCount; k++) begin
							base_q[k] <= nbase_q[k];
							cap_q[k] <= ncap_q[k];
						end
						state_q <= S_ACC;
					end else begin
						i_q <= i_q - 1'b1;
						j_q <= fill_q[ii - 1'b1];
					end
				end
				S_UPRD: begin
					wb_q <= 1'b1;
					wb_addr_q <= addr_t'(mv_dst);
					state_q <= S_UPSEL;
				end
				S_ACC: begin
					if (!sel_ok) begin
						out_pop_q <= '0;
						out_st_q <= (act_q == ActPop) ? StPopEmpty : StPushFull;
						out_e_q <= 1'b1;
						out_f_q <= 1'b1;
						out_v_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (act_q == ActPush) begin
						if (fill_q[si] < cap_q[si]) begin
							fill_q[si] <= fill_q[si] + 1'b1;
							out_st_q <= StOk;
							out_e_q <= 1'b0;
							out_f_q <= (fill_q[si] + 1'b1) == cap_q[si];
							out_pop_q <= '0;
							out_v_q <= 1'b1;
							state_q <= S_IDLE;
						end else if (!reloc_q) begin
							free_q <= '0;
							i_q <= '0;
							state_q <= S_SUM;
						end else begin
							out_st_q <= StPushFull;
							out_e_q <= fill_q[si] == '0;
							out_f_q <= 1'b1;
							out_pop_q <= '0;
							out_v_q <= 1'b1;
							state_q <= S_IDLE;
						end
					end else if (fill_q[si] == '0) begin
						out_st_q <= StPopEmpty;
						out_e_q <= 1'b1;
						out_f_q <= cap_q[si] == '0;
						out_pop_q <= '0;
						out_v_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						fill_q[si] <= fill_q[si] - 1'b1;
						out_st_q <= StOk;
						out_e_q <= fill_q[si] == cnt_t'(1);
						out_f_q <= (fill_q[si] - 1'b1) == cap_q[si];
						state_q <= S_POPW;
					end
				end
				S_POPW: begin
					out_pop_q <= rdata;
					out_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_IMPLIES(a_no_accept_busy, clk, arst_n, out_v_q, !s_axis_tready)
	`ASSERT_IMPLIES(a_status_legal, clk, arst_n, out_v_q, out_st_q != 2'd3)
	`ASSERT_NEXT(a_pop_reads, clk, arst_n, state_q == S_POPW, out_v_q)
	`ASSERT_IMPLIES(a_wb_in_move, clk, arst_n, wb_q,
		state_q == S_DNSEL || state_q == S_UPSEL)
endmodule
`default_nettype wire
